/* rtl/z80_alu_flags_unit_macros.svh */
// ----------------------------------------------------------------------------
// z80 alu flags unit assertion macros
// shared concurrent assertion forms, clocked on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef Z80_ALU_FLAGS_UNIT_MACROS_SVH
`define Z80_ALU_FLAGS_UNIT_MACROS_SVH

// plain property check
`define Z80AF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// implication check built on the plain form
`define Z80AF_ASSERT_IMP(lbl, ante, cons, msg) \
  `Z80AF_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/z80af_pkg.sv */
// ----------------------------------------------------------------------------
// z80af_pkg
// types and codes shared by the z80 alu flags unit and its submodules
// ----------------------------------------------------------------------------
package z80af_pkg;

  // operation codes
  typedef enum logic [3:0] {
    CMD_ADD16 = 4'd0,
    CMD_ADC16 = 4'd1,
    CMD_SUB16 = 4'd2,
    CMD_SBC16 = 4'd3,
    CMD_ADD8  = 4'd4,
    CMD_ADC8  = 4'd5,
    CMD_SUB8  = 4'd6,
    CMD_SBC8  = 4'd7,
    CMD_AND   = 4'd8,
    CMD_OR    = 4'd9,
    CMD_XOR   = 4'd10,
    CMD_CP    = 4'd11,
    CMD_INC8  = 4'd12,
    CMD_DEC8  = 4'd13
  } z80af_cmd_e;

  // operation class after decode
  typedef enum logic [1:0] {
    KIND_ARITH16,
    KIND_ARITH8,
    KIND_LOGIC,
    KIND_PASS
  } z80af_kind_e;

  // logic operation select
  typedef enum logic [1:0] {
    LOP_AND,
    LOP_OR,
    LOP_XOR
  } z80af_lop_e;

  // flag byte bit positions
  localparam int unsigned FL_S_BIT  = 7;
  localparam int unsigned FL_Z_BIT  = 6;
  localparam int unsigned FL_Y_BIT  = 5;
  localparam int unsigned FL_H_BIT  = 4;
  localparam int unsigned FL_X_BIT  = 3;
  localparam int unsigned FL_PV_BIT = 2;
  localparam int unsigned FL_N_BIT  = 1;
  localparam int unsigned FL_C_BIT  = 0;

  // input transaction
  typedef struct packed {
    logic [3:0]  cmd;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [7:0]  flags_in;
  } z80af_req_t;

  // result transaction
  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  flags_out;
  } z80af_rsp_t;

  // decoded control that travels down the pipe
  typedef struct packed {
    z80af_kind_e kind;
    logic        sub;       // subtract: b inverted, carry flags inverted
    logic        keep_szv;  // 16-bit add keeps S, Z and P/V
    logic        keep_c;    // inc and dec keep C
    logic        set_h;     // and sets H
    logic        res_a;     // compare returns operand a
    z80af_lop_e  lop;
  } z80af_ctrl_t;

  // stage 1 contents: decoded operands
  typedef struct packed {
    z80af_ctrl_t ctrl;
    logic [15:0] a;
    logic [15:0] bx;
    logic        cx;
    logic [7:0]  fi;
  } z80af_s1_t;

  // stage 2 contents: adder and logic results
  typedef struct packed {
    z80af_ctrl_t ctrl;
    logic [15:0] a;
    logic [15:0] bx;
    logic [16:0] sum;
    logic [7:0]  lres;
    logic [7:0]  fi;
  } z80af_s2_t;

endpackage

/* rtl/z80af_flag_gen.sv */
// ----------------------------------------------------------------------------
// z80af_flag_gen
// forms the result value and the new flag byte from the adder and logic
// outputs of stage 2
// ----------------------------------------------------------------------------
module z80af_flag_gen (
  input  z80af_pkg::z80af_s2_t  stage_i,
  output z80af_pkg::z80af_rsp_t rsp_o
);
  import z80af_pkg::*;

  logic [7:0]  res8;
  logic [15:0] res16;
  logic        h8, h16;
  logic        v8, v16;
  logic        c8, c16;
  logic [7:0]  f;
  logic [15:0] res;

  // carries into the half and sign positions, recovered from the sum
  assign res8  = stage_i.sum[7:0];
  assign res16 = stage_i.sum[15:0];
  assign h8  = stage_i.sum[4] ^ stage_i.a[4] ^ stage_i.bx[4] ^ stage_i.ctrl.sub;
  assign h16 = stage_i.sum[12] ^ stage_i.a[12] ^ stage_i.bx[12] ^ stage_i.ctrl.sub;
  assign v8  = ~(stage_i.a[7] ^ stage_i.bx[7]) & (stage_i.a[7] ^ stage_i.sum[7]);
  assign v16 = ~(stage_i.a[15] ^ stage_i.bx[15]) & (stage_i.a[15] ^ stage_i.sum[15]);
  assign c8  = stage_i.sum[8] ^ stage_i.ctrl.sub;
  assign c16 = stage_i.sum[16] ^ stage_i.ctrl.sub;

  // per-class result and flags; undocumented bits always pass
  always_comb begin
    f   = stage_i.fi;
    res = stage_i.a;
    case (stage_i.ctrl.kind)
      KIND_ARITH16: begin
        res          = res16;
        f[FL_H_BIT]  = h16;
        f[FL_N_BIT]  = stage_i.ctrl.sub;
        f[FL_C_BIT]  = c16;
        if (!stage_i.ctrl.keep_szv) begin
          f[FL_S_BIT]  = res16[15];
          f[FL_Z_BIT]  = (res16 == 16'h0000);
          f[FL_PV_BIT] = v16;
        end
      end
      KIND_ARITH8: begin
        res          = stage_i.ctrl.res_a ? stage_i.a : {8'h00, res8};
        f[FL_S_BIT]  = res8[7];
        f[FL_Z_BIT]  = (res8 == 8'h00);
        f[FL_H_BIT]  = h8;
        f[FL_PV_BIT] = v8;
        f[FL_N_BIT]  = stage_i.ctrl.sub;
        f[FL_C_BIT]  = stage_i.ctrl.keep_c ? stage_i.fi[FL_C_BIT] : c8;
      end
      KIND_LOGIC: begin
        res          = {8'h00, stage_i.lres};
        f[FL_S_BIT]  = stage_i.lres[7];
        f[FL_Z_BIT]  = (stage_i.lres == 8'h00);
        f[FL_H_BIT]  = stage_i.ctrl.set_h;
        f[FL_PV_BIT] = ~^stage_i.lres;
        f[FL_N_BIT]  = 1'b0;
        f[FL_C_BIT]  = 1'b0;
      end
      default: begin
        res = stage_i.a;
        f   = stage_i.fi;
      end
    endcase
    f[FL_Y_BIT] = stage_i.fi[FL_Y_BIT];
    f[FL_X_BIT] = stage_i.fi[FL_X_BIT];
  end

  assign rsp_o.result    = res;
  assign rsp_o.flags_out = f;

endmodule

/* rtl/z80_alu_flags_unit.sv */
// ----------------------------------------------------------------------------
// z80_alu_flags_unit
// pipelined z80 alu: 8 and 16-bit add, subtract, logic, compare, inc and dec
// with the full z80 flag byte
// ----------------------------------------------------------------------------
// usage
//   a transaction is accepted on a rising edge with start_i high and busy_o
//   low; req_i carries cmd, operand_a, operand_b and flags_in.
//   the result appears on rsp_o for exactly one cycle with done_o high,
//   after passing the s1, s2 and out registers.
//   throughput is one transaction per cycle: decode, the 17-bit adder and
//   the flag/result select each own one register stage.
//   results come out in the order their transactions went in.
//   the receiver cannot stall; every result is taken on the edge that ends
//   its strobe cycle.
//   reset clears all valid bits, so nothing is in flight afterwards; busy_o
//   is high during reset and until the ready flag rdy_q is set, then stays low.
// ----------------------------------------------------------------------------
module z80_alu_flags_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  z80af_pkg::z80af_req_t req_i,
  output logic                  done_o,
  output z80af_pkg::z80af_rsp_t rsp_o
);
  import z80af_pkg::*;

  logic        rdy_q;
  logic        accept;
  z80af_s1_t   s1_d, s1_q;
  logic        s1_vld_q;
  z80af_s2_t   s2_d, s2_q;
  logic        s2_vld_q;
  z80af_rsp_t  out_d, out_q;
  logic        out_vld_q;
  z80af_ctrl_t ctrl;
  logic [15:0] b_sel;
  logic        cx;
  logic        cin;
  logic [15:0] a_op;

  // ready flag is cleared by reset and set on the next clock edge after it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_q <= 1'b0;
    end else begin
      rdy_q <= 1'b1;
    end
  end

  assign busy_o = ~rdy_q;
  assign accept = start_i & rdy_q;
  assign cin    = req_i.flags_in[FL_C_BIT];

  // stage 1 decode: pick operand b, its inversion and the carry in
  always_comb begin
    ctrl  = '{kind: KIND_PASS, sub: 1'b0, keep_szv: 1'b0, keep_c: 1'b0,
              set_h: 1'b0, res_a: 1'b0, lop: LOP_AND};
    b_sel = req_i.operand_b;
    cx    = 1'b0;
    unique case (req_i.cmd)
      CMD_ADD16: begin
        ctrl.kind     = KIND_ARITH16;
        ctrl.keep_szv = 1'b1;
      end
      CMD_ADC16: begin
        ctrl.kind = KIND_ARITH16;
        cx        = cin;
      end
      CMD_SUB16: begin
        ctrl.kind = KIND_ARITH16;
        ctrl.sub  = 1'b1;
        cx        = 1'b1;
      end
      CMD_SBC16: begin
        ctrl.kind = KIND_ARITH16;
        ctrl.sub  = 1'b1;
        cx        = ~cin;
      end
      CMD_ADD8: begin
        ctrl.kind = KIND_ARITH8;
      end
      CMD_ADC8: begin
        ctrl.kind = KIND_ARITH8;
        cx        = cin;
      end
      CMD_SUB8: begin
        ctrl.kind = KIND_ARITH8;
        ctrl.sub  = 1'b1;
        cx        = 1'b1;
      end
      CMD_SBC8: begin
        ctrl.kind = KIND_ARITH8;
        ctrl.sub  = 1'b1;
        cx        = ~cin;
      end
      CMD_AND: begin
        ctrl.kind  = KIND_LOGIC;
        ctrl.lop   = LOP_AND;
        ctrl.set_h = 1'b1;
      end
      CMD_OR: begin
        ctrl.kind = KIND_LOGIC;
        ctrl.lop  = LOP_OR;
      end
      CMD_XOR: begin
        ctrl.kind = KIND_LOGIC;
        ctrl.lop  = LOP_XOR;
      end
      CMD_CP: begin
        ctrl.kind  = KIND_ARITH8;
        ctrl.sub   = 1'b1;
        ctrl.res_a = 1'b1;
        cx         = 1'b1;
      end
      CMD_INC8: begin
        // a + 0 + 1
        ctrl.kind   = KIND_ARITH8;
        ctrl.keep_c = 1'b1;
        b_sel       = 16'h0000;
        cx          = 1'b1;
      end
      CMD_DEC8: begin
        // a + ~1 + 1
        ctrl.kind   = KIND_ARITH8;
        ctrl.sub    = 1'b1;
        ctrl.keep_c = 1'b1;
        b_sel       = 16'h0001;
        cx          = 1'b1;
      end
      default: begin
        ctrl.kind = KIND_PASS;
      end
    endcase

    s1_d.ctrl = ctrl;
    s1_d.a    = req_i.operand_a;
    s1_d.cx   = cx;
    s1_d.fi   = req_i.flags_in;
    if (ctrl.kind == KIND_ARITH16) begin
      s1_d.bx = ctrl.sub ? ~b_sel : b_sel;
    end else begin
      s1_d.bx = {8'h00, (ctrl.sub ? ~b_sel[7:0] : b_sel[7:0])};
    end
  end

  // stage 2: one 17-bit add and the byte logic ops
  always_comb begin
    a_op = (s1_q.ctrl.kind == KIND_ARITH16) ? s1_q.a : {8'h00, s1_q.a[7:0]};
    s2_d.ctrl = s1_q.ctrl;
    s2_d.a    = s1_q.a;
    s2_d.bx   = s1_q.bx;
    s2_d.fi   = s1_q.fi;
    s2_d.sum  = {1'b0, a_op} + {1'b0, s1_q.bx} + {16'h0000, s1_q.cx};
    case (s1_q.ctrl.lop)
      LOP_AND: s2_d.lres = s1_q.a[7:0] & s1_q.bx[7:0];
      LOP_OR:  s2_d.lres = s1_q.a[7:0] | s1_q.bx[7:0];
      LOP_XOR: s2_d.lres = s1_q.a[7:0] ^ s1_q.bx[7:0];
      default: s2_d.lres = 8'h00;
    endcase
  end

  // stage 3: flags and result select
  z80af_flag_gen u_flag_gen (
    .stage_i (s2_q),
    .rsp_o   (out_d)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= accept;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  // payload registers, loaded with their valid bits
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_vld_q) begin
      s2_q <= s2_d;
    end
    if (s2_vld_q) begin
      out_q <= out_d;
    end
  end

  assign done_o = out_vld_q;
  assign rsp_o  = out_q;

endmodule

/* rtl/z80af_checker.sv */
// ----------------------------------------------------------------------------
// z80af_checker
// port-level checks on the z80 alu flags unit, attached by bind
// ----------------------------------------------------------------------------
`include "z80_alu_flags_unit_macros.svh"

module z80af_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input z80af_pkg::z80af_req_t req_i,
  input logic                  done_o,
  input z80af_pkg::z80af_rsp_t rsp_o
);
  import z80af_pkg::*;

  logic acc;
  assign acc = start_i & ~busy_o;

  // every accepted transaction yields a result on done_o
  `Z80AF_ASSERT_IMP(a_lat_fwd, acc, ##3 done_o, "accepted transaction gave no result")

  // no result without an earlier accepted transaction
  `Z80AF_ASSERT_IMP(a_lat_back, done_o, $past(acc, 3), "result without a transaction")

  // compare leaves the operand untouched
  `Z80AF_ASSERT_IMP(a_cp_keeps_a,
    done_o && $past(acc && (req_i.cmd == CMD_CP), 3),
    rsp_o.result == $past(req_i.operand_a, 3),
    "compare changed the operand")

  // undocumented flag bits pass through
  `Z80AF_ASSERT_IMP(a_xy_pass, done_o,
    (rsp_o.flags_out[FL_Y_BIT] == $past(req_i.flags_in[FL_Y_BIT], 3)) &&
    (rsp_o.flags_out[FL_X_BIT] == $past(req_i.flags_in[FL_X_BIT], 3)),
    "undocumented flag bits changed")

endmodule

bind z80_alu_flags_unit z80af_checker u_z80af_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);
